// ----- src/ufcrt_pkg.sv -----
// Shared types and constants for the frame reassembly tracker.
package ufcrt_pkg;

  localparam logic [31:0] HDR_MAGIC = 32'h43474941;
  localparam logic [7:0]  HDR_BYTES = 8'd32;
  localparam logic [7:0]  HDR_VERSION = 8'd1;

  typedef enum logic [3:0] {
    V_ACCEPTED = 4'd0,
    V_COMPLETE = 4'd1,
    V_DUPLICATE = 4'd2,
    V_STALE = 4'd3,
    V_INVALID = 4'd4,
    V_OVERSIZE = 4'd5,
    V_LEN_MISMATCH = 4'd6,
    V_TOO_MANY = 4'd7,
    V_TICK = 4'd8
  } verdict_t;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_TRACK = 2'd2
  } cmd_kind_t;

  localparam logic CFG_TTL = 1'b0;
  localparam logic CFG_MAXLEN = 1'b1;

  // Queue entry from the classifier to the table engine.
  typedef struct packed {
    cmd_kind_t   kind;
    verdict_t    verdict;
    logic [7:0]  source;
    logic [31:0] fid;
    logic [31:0] stamp;
    logic [31:0] flen;
    logic [31:0] frame_crc;
    logic [15:0] cidx;
    logic [15:0] ccnt;
    logic [15:0] plen;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_SCAN,
    ST_SCAN_DONE
  } eng_state_t;

endpackage

// ----- src/ufcrt_front.sv -----
// Front end: header checks and classification into engine commands.
module ufcrt_front
  import ufcrt_pkg::*;
#(
  parameter int SOURCES = 256,
  parameter int MAX_CHUNKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic        func,
  input  logic [15:0] datagram_len,
  input  logic [31:0] magic,
  input  logic [31:0] id_word,
  input  logic [31:0] fid,
  input  logic [31:0] stamp,
  input  logic [31:0] flen,
  input  logic [31:0] frame_crc,
  input  logic [15:0] cidx,
  input  logic [15:0] ccnt,
  input  logic [15:0] plen,
  input  logic [22:0] max_len,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  logic  valid_r;
  cmd_t  cmd_r;
  cmd_t  cmd_nxt;
  logic  bad_hdr;
  logic  over;
  logic [7:0] src;

  assign src = id_word[31:24];
  assign over = flen > {9'd0, max_len};
  assign bad_hdr = (magic != HDR_MAGIC) || (id_word[7:0] != HDR_VERSION) ||
                   (id_word[15:8] != HDR_BYTES) || (id_word[23:16] != 8'd0) ||
                   (ccnt == 16'd0) || (cidx >= ccnt) ||
                   (flen == 32'd0) || (plen == 16'd0) ||
                   ({1'b0, datagram_len} != {9'd0, HDR_BYTES} + {1'b0, plen});

  always_comb begin
    cmd_nxt = '0;
    cmd_nxt.source = src;
    cmd_nxt.fid = fid;
    cmd_nxt.stamp = stamp;
    cmd_nxt.flen = flen;
    cmd_nxt.frame_crc = frame_crc;
    cmd_nxt.cidx = cidx;
    cmd_nxt.ccnt = ccnt;
    cmd_nxt.plen = plen;
    cmd_nxt.kind = CMD_REPORT;
    if (func) begin
      cmd_nxt = '0;
      cmd_nxt.kind = CMD_TICK;
      cmd_nxt.verdict = V_TICK;
    end else if (datagram_len < {8'd0, HDR_BYTES}) begin
      cmd_nxt.verdict = V_INVALID;
    end else if (bad_hdr) begin
      cmd_nxt.verdict = over ? V_OVERSIZE : V_INVALID;
    end else if (over) begin
      cmd_nxt.verdict = V_OVERSIZE;
    end else if ({16'd0, ccnt} > MAX_CHUNKS) begin
      cmd_nxt.verdict = V_TOO_MANY;
    end else if ({24'd0, src} >= SOURCES) begin
      cmd_nxt.verdict = V_INVALID;
    end else begin
      cmd_nxt.kind = CMD_TRACK;
      cmd_nxt.verdict = V_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd = cmd_r;

endmodule

// ----- src/ufcrt_queue.sv -----
// Two-entry command queue between classifier and table engine.
module ufcrt_queue
  import ufcrt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output logic not_empty,
  output logic full,
  output cmd_t head
);

  cmd_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign not_empty = cnt_r != 2'd0;
  assign full = cnt_r == 2'd2;
  assign head = mem_r[rp_r];

endmodule

// ----- src/ufcrt_engine.sv -----
// Table engine: per-source entry lookup, update, completion and tick scan.
module ufcrt_engine
  import ufcrt_pkg::*;
#(
  parameter int SOURCES = 256,
  parameter int MAX_CHUNKS = 64,
  localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1,
  localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        busy,
  input  logic [12:0] ttl_ms,
  output logic        out_valid,
  output logic [3:0]  verdict,
  output logic        dropped_previous,
  output logic [7:0]  out_source,
  output logic [31:0] out_frame_id,
  output logic [31:0] out_timestamp,
  output logic [22:0] out_frame_len,
  output logic [31:0] out_frame_crc,
  output logic [8:0]  timeouts_count
);

  typedef struct packed {
    logic [31:0] frame;
    logic [31:0] stamp;
    logic [22:0] length;
    logic [31:0] check;
    logic [15:0] total;
    logic [31:0] born;
    logic [15:0] got;
    logic [21:0] bytes;
  } rec_t;

  rec_t                  rec_mem [SOURCES];
  logic [MAX_CHUNKS-1:0] map_mem [SOURCES];
  logic [SOURCES-1:0]    valid_r;

  eng_state_t state_r, state_nxt;
  cmd_t       cur_r;
  rec_t       rec_r;
  logic [MAX_CHUNKS-1:0] map_r;
  logic [31:0] time_r;
  logic [SW-1:0] scan_r;
  logic [8:0]  tcnt_r;
  logic [31:0] born_rd_r;
  logic [SW-1:0] chk_idx_r;
  logic        chk_r;

  logic        ov_r;
  logic [3:0]  vd_r;
  logic        dp_r;
  logic [7:0]  src_r;
  logic [31:0] fid_r, ts_r, crc_r;
  logic [22:0] len_r;
  logic [8:0]  tc_r;

  logic [SW-1:0] idx;
  logic [CW-1:0] bit_idx;
  logic          ent_live;
  logic          open_new;
  logic          dropped;
  rec_t          rec_w;
  logic [MAX_CHUNKS-1:0] map_w;
  logic          wr_en;
  logic          wr_go;
  logic          clr_en;
  logic [3:0]    vd_w;
  logic          rd_go;
  logic          scan_hit;

  assign idx = cur_r.source[SW-1:0];
  assign bit_idx = cur_r.cidx[CW-1:0];
  assign wr_go = wr_en && (state_r == ST_EVAL);
  assign scan_hit = chk_r && valid_r[chk_idx_r] &&
                    ((time_r - born_rd_r) > {19'd0, ttl_ms});

  // Read ports: one registered lookup per command, one registered scan read.
  always_ff @(posedge clk) begin
    if (rd_go) begin
      rec_r <= rec_mem[cmd.source[SW-1:0]];
      map_r <= map_mem[cmd.source[SW-1:0]];
    end
    // Read one entry per scan cycle; check it on the next.
    born_rd_r <= rec_mem[scan_r].born;
    chk_idx_r <= scan_r;
    if (wr_go) begin
      rec_mem[idx] <= rec_w;
      map_mem[idx] <= map_w;
    end
  end

  always_comb begin
    ent_live = valid_r[idx] && !((time_r - rec_r.born) > {19'd0, ttl_ms});
    open_new = 1'b0;
    dropped = 1'b0;
    rec_w = rec_r;
    map_w = map_r;
    wr_en = 1'b0;
    clr_en = 1'b0;
    vd_w = V_ACCEPTED;
    if (ent_live && cur_r.fid < rec_r.frame) begin
      vd_w = V_STALE;
    end else begin
      if (!ent_live || cur_r.fid > rec_r.frame) begin
        open_new = 1'b1;
        dropped = ent_live && (rec_r.got < rec_r.total);
        rec_w.frame = cur_r.fid;
        rec_w.stamp = cur_r.stamp;
        rec_w.length = cur_r.flen[22:0];
        rec_w.check = cur_r.frame_crc;
        rec_w.total = cur_r.ccnt;
        rec_w.born = time_r;
        rec_w.got = 16'd0;
        rec_w.bytes = 22'd0;
        map_w = '0;
        wr_en = 1'b1;
      end
      if (rec_w.frame != cur_r.fid || {9'd0, rec_w.length} != cur_r.flen ||
          rec_w.check != cur_r.frame_crc || rec_w.total != cur_r.ccnt) begin
        vd_w = V_INVALID;
      end else if (map_w[bit_idx]) begin
        vd_w = V_DUPLICATE;
      end else begin
        map_w[bit_idx] = 1'b1;
        rec_w.got = rec_w.got + 16'd1;
        rec_w.bytes = rec_w.bytes + {6'd0, cur_r.plen};
        wr_en = 1'b1;
        if (rec_w.got == rec_w.total) begin
          clr_en = 1'b1;
          vd_w = ({1'b0, rec_w.bytes} != rec_w.length) ? V_LEN_MISMATCH : V_COMPLETE;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_go = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          rd_go = 1'b1;
          case (cmd.kind)
            CMD_TRACK: state_nxt = ST_READ;
            CMD_TICK:  state_nxt = ST_SCAN;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_IDLE;
      ST_SCAN: if (scan_r == SW'(SOURCES - 1)) state_nxt = ST_SCAN_DONE;
      ST_SCAN_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;
  assign busy = state_r != ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      time_r <= 32'd0;
      ov_r <= 1'b0;
      scan_r <= '0;
      tcnt_r <= 9'd0;
      chk_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= 1'b0;
      chk_r <= (state_r == ST_SCAN);
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur_r <= cmd;
            if (cmd.kind == CMD_REPORT) begin
              ov_r <= 1'b1;
              vd_r <= cmd.verdict;
              dp_r <= 1'b0;
              src_r <= cmd.source;
              fid_r <= cmd.fid;
              ts_r <= 32'd0;
              len_r <= 23'd0;
              crc_r <= 32'd0;
              tc_r <= 9'd0;
            end else if (cmd.kind == CMD_TICK) begin
              time_r <= time_r + 32'd1;
              scan_r <= '0;
              tcnt_r <= 9'd0;
            end
          end
        end
        ST_EVAL: begin
          ov_r <= 1'b1;
          vd_r <= vd_w;
          dp_r <= dropped;
          src_r <= cur_r.source;
          fid_r <= cur_r.fid;
          ts_r <= clr_en ? rec_w.stamp : 32'd0;
          len_r <= clr_en ? rec_w.length : 23'd0;
          crc_r <= clr_en ? rec_w.check : 32'd0;
          tc_r <= 9'd0;
          if (clr_en) valid_r[idx] <= 1'b0;
          else if (open_new) valid_r[idx] <= 1'b1;
        end
        ST_SCAN: begin
          // Expire the entry read on the previous cycle.
          if (scan_hit) begin
            valid_r[chk_idx_r] <= 1'b0;
            tcnt_r <= tcnt_r + 9'd1;
          end
          scan_r <= scan_r + SW'(1);
        end
        ST_SCAN_DONE: begin
          if (scan_hit) valid_r[chk_idx_r] <= 1'b0;
          ov_r <= 1'b1;
          vd_r <= V_TICK;
          dp_r <= 1'b0;
          src_r <= 8'd0;
          fid_r <= 32'd0;
          ts_r <= 32'd0;
          len_r <= 23'd0;
          crc_r <= 32'd0;
          tc_r <= tcnt_r + {8'd0, scan_hit};
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign verdict = vd_r;
  assign dropped_previous = dp_r;
  assign out_source = src_r;
  assign out_frame_id = fid_r;
  assign out_timestamp = ts_r;
  assign out_frame_len = len_r;
  assign out_frame_crc = crc_r;
  assign timeouts_count = tc_r;

endmodule

// ----- src/udp_frame_chunk_reassembly_tracker_unit.sv -----
// Packet items pass the front register, the queue, the engine's idle, read and eval
// states and the output register; rejected headers skip read and eval. Tick items
// scan the table one source a cycle, then pass the scan-done state before out_valid.
// The table engine's lookup and scan set the rate; one item is in flight at a time.
// Synchronous active-low reset clears all entries, the clock and the queue.
// Results show for one cycle on out_valid; the receiver cannot stall.
module udp_frame_chunk_reassembly_tracker_unit
  import ufcrt_pkg::*;
#(
  parameter int SOURCES = 256,
  parameter int MAX_CHUNKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [15:0] in_datagram_len,
  input  logic [31:0] in_magic,
  input  logic [31:0] in_id_word,
  input  logic [31:0] in_frame_id,
  input  logic [31:0] in_timestamp_ms,
  input  logic [31:0] in_frame_len,
  input  logic [31:0] in_frame_crc,
  input  logic [15:0] in_chunk_index,
  input  logic [15:0] in_chunk_count,
  input  logic [15:0] in_payload_len,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [22:0] cfg_data,
  output logic        out_valid,
  output logic [3:0]  out_verdict,
  output logic        out_dropped_previous,
  output logic [7:0]  out_source,
  output logic [31:0] out_frame_id,
  output logic [31:0] out_timestamp,
  output logic [22:0] out_frame_len,
  output logic [31:0] out_frame_crc,
  output logic [8:0]  out_timeouts_count
);

  logic [12:0] ttl_r;
  logic [22:0] maxlen_r;
  logic        take;
  logic        f_valid;
  cmd_t        f_cmd;
  logic        q_ne, q_full, q_pop, e_busy;
  cmd_t        q_head;
  logic        pend_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= 13'd250;
      maxlen_r <= 23'd524288;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TTL:    ttl_r <= cfg_data[12:0];
        CFG_MAXLEN: maxlen_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold one item in flight at a time between front and engine.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (take) begin
      pend_r <= 1'b1;
    end else if (q_pop) begin
      pend_r <= 1'b0;
    end
  end

  assign busy = pend_r || f_valid || q_ne || e_busy || q_full;
  assign take = start && !busy;

  ufcrt_front #(.SOURCES(SOURCES), .MAX_CHUNKS(MAX_CHUNKS)) u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .func(in_func),
    .datagram_len(in_datagram_len), .magic(in_magic), .id_word(in_id_word),
    .fid(in_frame_id), .stamp(in_timestamp_ms),
    .flen(in_frame_len), .frame_crc(in_frame_crc),
    .cidx(in_chunk_index), .ccnt(in_chunk_count),
    .plen(in_payload_len), .max_len(maxlen_r),
    .cmd_valid(f_valid), .cmd(f_cmd)
  );

  ufcrt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(f_valid), .push_data(f_cmd),
    .pop(q_pop), .not_empty(q_ne), .full(q_full), .head(q_head)
  );

  ufcrt_engine #(.SOURCES(SOURCES), .MAX_CHUNKS(MAX_CHUNKS)) u_engine (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_ne), .cmd(q_head), .cmd_pop(q_pop),
    .busy(e_busy), .ttl_ms(ttl_r), .out_valid(out_valid), .verdict(out_verdict),
    .dropped_previous(out_dropped_previous), .out_source(out_source),
    .out_frame_id(out_frame_id), .out_timestamp(out_timestamp),
    .out_frame_len(out_frame_len), .out_frame_crc(out_frame_crc),
    .timeouts_count(out_timeouts_count)
  );

endmodule
